// File: rtl/lpr_pkg.sv
package lpr_pkg;

	// Build-time defaults
	localparam int FRAME_COUNT_DEF = 16;
	localparam int PAGE_BITS_DEF   = 16;

	// Fixed field widths of the channels
	localparam int PAGE_W  = 16;
	localparam int INDEX_W = 4;
	localparam int COUNT_W = 32;
	localparam int CFG_W   = 5;

	// Frame count after reset
	localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(4);

	// Saturation value of the fault total
	localparam logic [COUNT_W-1:0] FAULT_MAX = {COUNT_W{1'b1}};

endpackage

// File: rtl/lpr_if.sv
// Page reference channel
interface lpr_ref_if import lpr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PAGE_W-1:0] page_number;
	logic              last_reference;

	modport source (output valid, output page_number, output last_reference, input ready);
	modport sink   (input valid, input page_number, input last_reference, output ready);
endinterface

// Result channel
interface lpr_res_if import lpr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               hit;
	logic [INDEX_W-1:0] frame_index;
	logic               evicted_valid;
	logic [PAGE_W-1:0]  evicted_page;
	logic [COUNT_W-1:0] fault_count;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output fault_count, input ready);
	modport sink   (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input fault_count, output ready);
endinterface

// File: rtl/lru_page_replacement.sv
// Channel     Dir   Fields
// page_ref    in    page_number[15:0], last_reference
// page_res    out   hit, frame_index[3:0], evicted_valid, evicted_page[15:0], fault_count[31:0]
// cfg_*       in    cfg_wen, cfg_wdata[4:0] (frames_in_use)
//
// One item per cycle sustained while page_res.ready holds; an accepted item is captured in the input register,
// and the result register loads from the input register when the result register is free.
// The lookup, victim choice and rank update sit between the input register and
// the result register, and the frame table is updated at the same edge.
// arst_n clears the run state and sets frames_in_use to 4; page contents are not reset.
// A stalled result holds in its register while one more item waits in the input register.
module lru_page_replacement import lpr_pkg::*; #(
	parameter int FRAME_COUNT = FRAME_COUNT_DEF,
	parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [CFG_W-1:0] cfg_wdata,
	lpr_ref_if.sink          page_ref,
	lpr_res_if.source        page_res
);

	localparam int IDX_W  = $clog2(FRAME_COUNT);
	localparam int RANK_W = $clog2(FRAME_COUNT);
	localparam int AW     = ($clog2(FRAME_COUNT + 1) > CFG_W) ? $clog2(FRAME_COUNT + 1) : CFG_W;

	// Lowest set bit of a frame vector
	function automatic logic [IDX_W-1:0] first_set(input logic [FRAME_COUNT-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
			if (v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

	logic [CFG_W-1:0]     frames_q;
	logic                 s1_valid;
	logic [PAGE_BITS-1:0] page_s1;
	logic                 last_s1;

	logic [PAGE_BITS-1:0] page_q  [FRAME_COUNT];
	logic [RANK_W-1:0]    rank_q  [FRAME_COUNT];
	logic [FRAME_COUNT-1:0] valid_q;
	logic [COUNT_W-1:0]   fault_total_q;

	logic                 res_valid_q;
	logic                 hit_q;
	logic [INDEX_W-1:0]   frame_index_q;
	logic                 evicted_valid_q;
	logic [PAGE_W-1:0]    evicted_page_q;
	logic [COUNT_W-1:0]   fault_count_q;

	logic                 adv;
	logic                 fire;
	logic [AW-1:0]        cfg_ext;
	logic [AW-1:0]        active;
	logic [FRAME_COUNT-1:0] act_mask;
	logic [FRAME_COUNT-1:0] match_vec;
	logic [FRAME_COUNT-1:0] empty_vec;
	logic [FRAME_COUNT-1:0] lru_vec;
	logic                 hit_w;
	logic                 empty_w;
	logic                 evict_w;
	logic [IDX_W-1:0]     idx_w;
	logic [RANK_W-1:0]    cur_rank;
	logic [RANK_W-1:0]    rank_next [FRAME_COUNT];
	logic [COUNT_W-1:0]   fault_next;

	// Handshake: result register frees the input register
	assign adv            = !res_valid_q || page_res.ready;
	assign fire           = s1_valid && adv;
	assign page_ref.ready = !s1_valid || adv;

	// Active frame count, clamped to 1..FRAME_COUNT
	assign cfg_ext = AW'(frames_q);
	always_comb begin
		if (cfg_ext == '0) begin
			active = AW'(1);
		end else if (cfg_ext > AW'(FRAME_COUNT)) begin
			active = AW'(FRAME_COUNT);
		end else begin
			active = cfg_ext;
		end
	end

	// Per-frame lookup vectors
	always_comb begin
		for (int j = 0; j < FRAME_COUNT; j++) begin
			act_mask[j]  = AW'(j) < active;
			match_vec[j] = act_mask[j] && valid_q[j] && (page_q[j] == page_s1);
			empty_vec[j] = act_mask[j] && !valid_q[j];
		end
	end

	// Oldest active frame: rank beats every other active frame, lower index wins ties
	always_comb begin
		for (int j = 0; j < FRAME_COUNT; j++) begin
			lru_vec[j] = act_mask[j];
			for (int k = 0; k < FRAME_COUNT; k++) begin
				if (k != j && act_mask[k]) begin
					if (!((rank_q[j] > rank_q[k]) || ((rank_q[j] == rank_q[k]) && (j < k))))
						lru_vec[j] = 1'b0;
				end
			end
		end
	end

	// Frame choice
	assign hit_w   = |match_vec;
	assign empty_w = |empty_vec;
	assign evict_w = !hit_w && !empty_w;
	always_comb begin
		if (hit_w) begin
			idx_w = first_set(match_vec);
		end else if (empty_w) begin
			idx_w = first_set(empty_vec);
		end else begin
			idx_w = first_set(lru_vec);
		end
	end
	assign cur_rank = rank_q[idx_w];

	// Rank update: touched frame goes to 0, younger valid frames age (all on a fill)
	always_comb begin
		for (int j = 0; j < FRAME_COUNT; j++) begin
			if (IDX_W'(j) == idx_w) begin
				rank_next[j] = '0;
			end else if (valid_q[j] && ((!hit_w && empty_w) || (rank_q[j] < cur_rank))) begin
				rank_next[j] = rank_q[j] + RANK_W'(1);
			end else begin
				rank_next[j] = rank_q[j];
			end
		end
	end

	// Saturating fault total
	assign fault_next = (hit_w || fault_total_q == FAULT_MAX) ? fault_total_q
		: fault_total_q + COUNT_W'(1);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (cfg_wen) begin
			frames_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (page_ref.ready) begin
			s1_valid <= page_ref.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (page_ref.ready && page_ref.valid) begin
			page_s1 <= PAGE_BITS'(page_ref.page_number);
			last_s1 <= page_ref.last_reference;
		end
	end

	// Run state: valid bits, ranks, fault total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			fault_total_q <= '0;
			for (int j = 0; j < FRAME_COUNT; j++) rank_q[j] <= '0;
		end else if (fire) begin
			if (last_s1) begin
				valid_q       <= '0;
				fault_total_q <= '0;
				for (int j = 0; j < FRAME_COUNT; j++) rank_q[j] <= '0;
			end else begin
				valid_q[idx_w] <= 1'b1;
				fault_total_q  <= fault_next;
				for (int j = 0; j < FRAME_COUNT; j++) rank_q[j] <= rank_next[j];
			end
		end
	end

	// Page table, written on every fault
	always_ff @(posedge clk) begin
		if (fire && !hit_w) begin
			page_q[idx_w] <= page_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_q           <= hit_w;
			frame_index_q   <= INDEX_W'(idx_w);
			evicted_valid_q <= evict_w;
			evicted_page_q  <= evict_w ? PAGE_W'(page_q[idx_w]) : '0;
			fault_count_q   <= fault_next;
		end
	end

	assign page_res.valid         = res_valid_q;
	assign page_res.hit           = hit_q;
	assign page_res.frame_index   = frame_index_q;
	assign page_res.evicted_valid = evicted_valid_q;
	assign page_res.evicted_page  = evicted_page_q;
	assign page_res.fault_count   = fault_count_q;

	// Checks
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_valid_q)
		else $error("accepted item produced no result");

	a_last_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> (valid_q == '0) && (fault_total_q == '0))
		else $error("run state not cleared after last reference");

	a_hit_keeps_total: assert property (@(posedge clk) disable iff (!arst_n)
		fire && hit_w && !last_s1 |=> $stable(fault_total_q))
		else $error("fault total moved on a hit");

	a_touched_is_mru: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !last_s1 |=> valid_q[$past(idx_w)] && (rank_q[$past(idx_w)] == '0))
		else $error("touched frame not valid and most recent");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && hit_q |-> !evicted_valid_q && (evicted_page_q == '0))
		else $error("eviction reported on a hit");

endmodule
